[src/qts_pkg.sv]
package qts_pkg;

   typedef enum logic [2:0] {
      CL_OTHER = 3'd0,
      CL_BLANK = 3'd1,
      CL_ESC   = 3'd2,
      CL_DQ    = 3'd3,
      CL_END   = 3'd4,
      CL_SQ    = 3'd5
   } char_class_type;

   typedef enum logic [3:0] {
      ST_START   = 4'd0,
      ST_DQ      = 4'd1,
      ST_DQ_ESC  = 4'd2,
      ST_WORD    = 4'd3,
      ST_ESC     = 4'd4,
      ST_DONE    = 4'd5,
      ST_SQ      = 4'd6,
      ST_SQ_ESC  = 4'd7,
      ST_NOTOKEN = 4'd8
   } dfa_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_char;
      logic       token_end;
      logic       token_empty;
      logic       line_end;
      logic [7:0] token_count;
   } rsp_type;

   localparam int unsigned MaxTokens = 255;
   localparam int unsigned CountCapInt = (MaxTokens < 255) ? MaxTokens : 255;
   localparam logic [7:0] CountCap = CountCapInt[7:0];

   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab = 8'h09;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChDquote = 8'h22;
   localparam logic [7:0] ChSquote = 8'h27;
   localparam logic [7:0] ChNul = 8'h00;

   localparam dfa_state_type NextTab [9][6] = '{
      '{ST_WORD, ST_START, ST_ESC, ST_DQ, ST_NOTOKEN, ST_SQ},
      '{ST_DQ, ST_DQ, ST_DQ_ESC, ST_WORD, ST_DONE, ST_DQ},
      '{ST_DQ, ST_DQ, ST_DQ, ST_DQ, ST_DONE, ST_DQ},
      '{ST_WORD, ST_DONE, ST_ESC, ST_DQ, ST_DONE, ST_SQ},
      '{ST_WORD, ST_WORD, ST_WORD, ST_WORD, ST_DONE, ST_WORD},
      '{ST_START, ST_START, ST_START, ST_START, ST_START, ST_START},
      '{ST_SQ, ST_SQ, ST_SQ_ESC, ST_SQ, ST_DONE, ST_WORD},
      '{ST_SQ, ST_SQ, ST_SQ, ST_SQ, ST_DONE, ST_SQ},
      '{ST_START, ST_START, ST_START, ST_START, ST_START, ST_START}
   };

   localparam logic [5:0] KeepTab [9] = '{
      6'b000001,
      6'b100011,
      6'b101111,
      6'b000001,
      6'b101111,
      6'b000000,
      6'b001011,
      6'b101111,
      6'b000000
   };

   function automatic char_class_type class_of(input logic [7:0] b);
      char_class_type c;
      c = CL_OTHER;
      if (b == ChNul) begin
         c = CL_END;
      end else if (b == ChBackslash) begin
         c = CL_ESC;
      end else if (b == ChDquote) begin
         c = CL_DQ;
      end else if (b == ChSquote) begin
         c = CL_SQ;
      end else if (b == ChSpace || b == ChTab) begin
         c = CL_BLANK;
      end
      return c;
   endfunction

   // Done, no-token and undefined codes all behave as the start state.
   function automatic dfa_state_type live_state(input dfa_state_type s);
      dfa_state_type r;
      case (s)
         ST_DQ, ST_DQ_ESC, ST_WORD, ST_ESC, ST_SQ, ST_SQ_ESC: begin
            r = s;
         end
         default: begin
            r = ST_START;
         end
      endcase
      return r;
   endfunction

endpackage

[src/quoted_token_splitter_top.sv]
// Splits a command line into shell-style tokens, one byte per transaction.
// The request channel carries one byte of the line in req_in_byte; a zero
// byte ends the line. The response channel carries a transaction for every
// kept token character, every finished token and the end of each line;
// quote marks, escape marks and blanks between tokens give no transaction.
// A byte is captured in an input register at the edge that accepts it and
// decoded from that register by the tokenizer state machine; its response
// is loaded into the output register once that register is free, and
// rsp_valid is driven from the output register.
// Throughput is one byte per cycle while the receiver does not hold rsp_stall.
// A new request is accepted while a finished response waits to be taken.
// When the receiver holds rsp_stall, the output register keeps its response
// and the input register backs up; req_stall then rises until the response
// is taken. Synchronous reset empties both registers and returns the
// tokenizer to the start of a line with a zero token count.
module quoted_token_splitter_top
   import qts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_char,
   output logic       rsp_token_end,
   output logic       rsp_token_empty,
   output logic       rsp_line_end,
   output logic [7:0] rsp_token_count
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_ready;
   logic       fire;
   logic       accept;
   logic       rsp_gen;
   rsp_type    rsp_next;
   rsp_type    rsp_q;

   assign fire = in_valid_ff & out_ready;
   assign req_stall = in_valid_ff & ~out_ready;
   assign accept = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
   end

   qts_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .rsp_gen (rsp_gen),
      .rsp     (rsp_next)
   );

   qts_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire & rsp_gen),
      .rsp_in    (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_q     (rsp_q),
      .ready     (out_ready)
   );

   assign rsp_out_byte = rsp_q.out_byte;
   assign rsp_has_char = rsp_q.has_char;
   assign rsp_token_end = rsp_q.token_end;
   assign rsp_token_empty = rsp_q.token_empty;
   assign rsp_line_end = rsp_q.line_end;
   assign rsp_token_count = rsp_q.token_count;

endmodule

[src/qts_step.sv]
module qts_step
   import qts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output logic       rsp_gen,
   output rsp_type    rsp
);

   dfa_state_type  state_ff, state_in;
   logic           nonempty_ff, nonempty_in;
   logic           skip_ff, skip_in;
   logic [7:0]     seen_ff, seen_in;

   char_class_type cls;
   dfa_state_type  cur;
   dfa_state_type  nxt;
   logic           keep;
   logic           empty;
   logic [7:0]     seen_inc;

   always_comb begin
      cls = class_of(in_byte);
      cur = live_state(state_ff);
      nxt = NextTab[cur][cls];
      keep = KeepTab[cur][cls];
      empty = ~nonempty_ff;
      seen_inc = (!empty && seen_ff < CountCap) ? seen_ff + 8'd1 : seen_ff;

      state_in = state_ff;
      nonempty_in = nonempty_ff;
      skip_in = skip_ff;
      seen_in = seen_ff;
      rsp_gen = 1'b0;
      rsp = '0;
      rsp.token_count = seen_ff;

      if (skip_ff) begin
         if (cls == CL_END) begin
            rsp_gen = 1'b1;
            rsp.line_end = 1'b1;
            state_in = ST_START;
            nonempty_in = 1'b0;
            skip_in = 1'b0;
            seen_in = '0;
         end
      end else if (keep) begin
         rsp_gen = 1'b1;
         rsp.out_byte = in_byte;
         rsp.has_char = 1'b1;
         nonempty_in = 1'b1;
         state_in = nxt;
      end else if (nxt == ST_NOTOKEN) begin
         rsp_gen = 1'b1;
         rsp.line_end = 1'b1;
         state_in = ST_START;
         nonempty_in = 1'b0;
         skip_in = 1'b0;
         seen_in = '0;
      end else if (nxt == ST_DONE) begin
         rsp_gen = 1'b1;
         rsp.token_end = 1'b1;
         rsp.token_empty = empty;
         rsp.token_count = seen_inc;
         state_in = ST_START;
         nonempty_in = 1'b0;
         if (cls == CL_END) begin
            rsp.line_end = 1'b1;
            skip_in = 1'b0;
            seen_in = '0;
         end else begin
            skip_in = empty;
            seen_in = seen_inc;
         end
      end else begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         nonempty_ff <= 1'b0;
         skip_ff <= 1'b0;
         seen_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         nonempty_ff <= nonempty_in;
         skip_ff <= skip_in;
         seen_ff <= seen_in;
      end
   end

endmodule

[src/qts_out.sv]
module qts_out
   import qts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_q,
   output logic    ready
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign ready = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_q = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule
